>>> hw/rtl/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// shared constants, types and controller/datapath interface structs for the
// fat boot sector parser
// ----------------------------------------------------------------------------
package fbs_pkg;

    // byte offset counter, saturates once past the kept fields
    localparam int unsigned OffW = 6;
    localparam logic [OffW-1:0] OFF_MAX = '1;

    // boot sector offsets
    localparam logic [OffW-1:0] OFF_JMP0     = 6'd0;
    localparam logic [OffW-1:0] OFF_JMP1     = 6'd1;
    localparam logic [OffW-1:0] OFF_JMP2     = 6'd2;
    localparam logic [OffW-1:0] OFF_BPS_LO   = 6'd11;
    localparam logic [OffW-1:0] OFF_BPS_HI   = 6'd12;
    localparam logic [OffW-1:0] OFF_SPC      = 6'd13;
    localparam logic [OffW-1:0] OFF_RSV_LO   = 6'd14;
    localparam logic [OffW-1:0] OFF_RSV_HI   = 6'd15;
    localparam logic [OffW-1:0] OFF_FATS     = 6'd16;
    localparam logic [OffW-1:0] OFF_ENT_LO   = 6'd17;
    localparam logic [OffW-1:0] OFF_ENT_HI   = 6'd18;
    localparam logic [OffW-1:0] OFF_TOT16_LO = 6'd19;
    localparam logic [OffW-1:0] OFF_TOT16_HI = 6'd20;
    localparam logic [OffW-1:0] OFF_SPF_LO   = 6'd22;
    localparam logic [OffW-1:0] OFF_SPF_HI   = 6'd23;
    localparam logic [OffW-1:0] OFF_TOT32_B0 = 6'd32;
    localparam logic [OffW-1:0] OFF_TOT32_B1 = 6'd33;
    localparam logic [OffW-1:0] OFF_TOT32_B2 = 6'd34;
    localparam logic [OffW-1:0] OFF_TOT32_B3 = 6'd35;
    localparam logic [OffW-1:0] OFF_EXT_SIG  = 6'd38;
    localparam logic [OffW-1:0] OFF_SER_B0   = 6'd39;
    localparam logic [OffW-1:0] OFF_SER_B1   = 6'd40;
    localparam logic [OffW-1:0] OFF_SER_B2   = 6'd41;
    localparam logic [OffW-1:0] OFF_SER_B3   = 6'd42;

    // signature bytes
    localparam logic [7:0] JMP_B0    = 8'hEB;
    localparam logic [7:0] JMP_B1    = 8'h3C;
    localparam logic [7:0] JMP_B2    = 8'h90;
    localparam logic [7:0] EXT_SIG_A = 8'h28;
    localparam logic [7:0] EXT_SIG_B = 8'h29;

    // cluster count thresholds
    localparam logic [31:0] FAT16_MIN = 32'd4096;
    localparam logic [31:0] FAT32_MIN = 32'd65526;

    typedef enum logic [1:0] {
        FAT_12 = 2'd0,
        FAT_16 = 2'd1,
        FAT_32 = 2'd2
    } t_fat_kind;

    localparam int unsigned TDATA_W = 216;
    localparam int unsigned TUSER_W = 3;

    typedef struct packed {
        logic capture;
        logic clear;
        logic base_load;
        logic root_start;
        logic root_load;
        logic ovh_load;
        logic clus_start;
        logic clus_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/fbs_div.sv
// ----------------------------------------------------------------------------
// fbs_div
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle, done pulses once the quotient is final
// ----------------------------------------------------------------------------
module fbs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_count;
    logic [15:0] r_rem;
    logic [15:0] r_divisor;
    logic [31:0] r_quo;

    logic [16:0] w_trial;
    logic [16:0] w_sub;
    logic        w_take;

    always_comb begin
        w_trial = {r_rem, r_quo[31]};
        w_sub   = w_trial - {1'b0, r_divisor};
        w_take  = (w_trial >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 5'd1;
                if (r_count == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], w_take};
            r_rem <= w_take ? w_sub[15:0] : w_trial[15:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hw/rtl/fbs_datapath.sv
// ----------------------------------------------------------------------------
// fbs_datapath
// field capture, geometry arithmetic around the shared divider, and the
// result register on the output stream
// ----------------------------------------------------------------------------
module fbs_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbs_pkg::t_cmd                 i_cmd,
    output fbs_pkg::t_status              o_status,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [fbs_pkg::TDATA_W-1:0]   o_m_data,
    output logic [fbs_pkg::TUSER_W-1:0]   o_m_user
);
    import fbs_pkg::*;

    // captured fields
    logic [OffW-1:0] r_offset;
    logic            r_sig_good;
    logic            r_sig_full;
    logic            r_ext;
    logic [15:0]     r_bps;
    logic [7:0]      r_spc;
    logic [15:0]     r_rsv;
    logic [7:0]      r_fats;
    logic [15:0]     r_ent;
    logic [15:0]     r_tot16;
    logic [15:0]     r_spf;
    logic [31:0]     r_tot32;
    logic [31:0]     r_serial;

    // derived values
    logic [23:0]     r_database;
    logic [21:0]     r_rootdir;
    logic [24:0]     r_overhead;
    logic            r_fits;
    logic [31:0]     r_clusters;

    // result register
    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic [TUSER_W-1:0] r_out_user;

    logic        w_div_done;
    logic [31:0] w_quotient;
    logic [31:0] w_total;
    logic [21:0] w_root_num;
    logic [32:0] w_diff;
    logic [31:0] w_div_num;
    logic [15:0] w_div_den;
    logic        w_sig;
    logic        w_root_big;
    logic        w_ok;
    logic [31:0] w_clus;
    logic [31:0] w_entries;
    logic [15:0] w_root_out;
    logic [31:0] w_serial;
    t_fat_kind   w_kind;
    logic [TDATA_W-1:0] w_tdata;
    logic [TUSER_W-1:0] w_tuser;

    // byte capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_offset   <= '0;
            r_sig_good <= 1'b1;
            r_sig_full <= 1'b0;
            r_ext      <= 1'b0;
            r_bps      <= '0;
            r_spc      <= '0;
            r_rsv      <= '0;
            r_fats     <= '0;
            r_ent      <= '0;
            r_tot16    <= '0;
            r_spf      <= '0;
            r_tot32    <= '0;
            r_serial   <= '0;
        end else if (i_cmd.capture) begin
            if (r_offset != OFF_MAX) begin
                r_offset <= r_offset + OffW'(1);
            end
            unique case (r_offset)
                OFF_JMP0: begin
                    if (i_data_byte != JMP_B0) r_sig_good <= 1'b0;
                end
                OFF_JMP1: begin
                    if (i_data_byte != JMP_B1) r_sig_good <= 1'b0;
                end
                OFF_JMP2: begin
                    if (i_data_byte != JMP_B2) r_sig_good <= 1'b0;
                    r_sig_full <= 1'b1;
                end
                OFF_BPS_LO:   r_bps[7:0]       <= i_data_byte;
                OFF_BPS_HI:   r_bps[15:8]      <= i_data_byte;
                OFF_SPC:      r_spc            <= i_data_byte;
                OFF_RSV_LO:   r_rsv[7:0]       <= i_data_byte;
                OFF_RSV_HI:   r_rsv[15:8]      <= i_data_byte;
                OFF_FATS:     r_fats           <= i_data_byte;
                OFF_ENT_LO:   r_ent[7:0]       <= i_data_byte;
                OFF_ENT_HI:   r_ent[15:8]      <= i_data_byte;
                OFF_TOT16_LO: r_tot16[7:0]     <= i_data_byte;
                OFF_TOT16_HI: r_tot16[15:8]    <= i_data_byte;
                OFF_SPF_LO:   r_spf[7:0]       <= i_data_byte;
                OFF_SPF_HI:   r_spf[15:8]      <= i_data_byte;
                OFF_TOT32_B0: r_tot32[7:0]     <= i_data_byte;
                OFF_TOT32_B1: r_tot32[15:8]    <= i_data_byte;
                OFF_TOT32_B2: r_tot32[23:16]   <= i_data_byte;
                OFF_TOT32_B3: r_tot32[31:24]   <= i_data_byte;
                OFF_EXT_SIG: begin
                    r_ext <= (i_data_byte == EXT_SIG_A) || (i_data_byte == EXT_SIG_B);
                end
                OFF_SER_B0:   r_serial[7:0]    <= i_data_byte;
                OFF_SER_B1:   r_serial[15:8]   <= i_data_byte;
                OFF_SER_B2:   r_serial[23:16]  <= i_data_byte;
                OFF_SER_B3:   r_serial[31:24]  <= i_data_byte;
                default: ;
            endcase
        end
    end

    // divider operands
    always_comb begin
        w_total    = (r_tot16 == 16'd0) ? r_tot32 : {16'd0, r_tot16};
        w_root_num = {1'b0, r_ent, 5'd0} + {6'd0, r_bps} - 22'd1;
        w_diff     = {1'b0, w_total} - {8'd0, r_overhead};
        w_div_num  = i_cmd.root_start ? {10'd0, w_root_num} : w_diff[31:0];
        w_div_den  = i_cmd.root_start ? r_bps : {8'd0, r_spc};
    end

    fbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start | i_cmd.clus_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_load) begin
            r_database <= {8'd0, r_rsv} + ({16'd0, r_fats} * {8'd0, r_spf});
        end
        if (i_cmd.root_load) begin
            r_rootdir <= (r_bps == 16'd0) ? 22'd0 : w_quotient[21:0];
        end
        if (i_cmd.ovh_load) begin
            r_overhead <= {1'b0, r_database} + {3'd0, r_rootdir};
        end
        if (i_cmd.clus_start) begin
            r_fits <= !w_diff[32];
        end
        if (i_cmd.clus_load) begin
            r_clusters <= w_quotient;
        end
    end

    // result assembly
    always_comb begin
        w_sig      = r_sig_good && r_sig_full;
        w_root_big = |r_rootdir[21:16];
        w_ok       = w_sig && (r_bps != 16'd0) && (r_spc != 8'd0) && r_fits && !w_root_big;
        w_clus     = w_ok ? r_clusters : 32'd0;
        w_entries  = w_ok ? (r_clusters + 32'd2) : 32'd0;
        w_root_out = w_root_big ? 16'hFFFF : r_rootdir[15:0];
        w_serial   = r_ext ? r_serial : 32'd0;
        if (!w_ok) begin
            w_kind = FAT_12;
        end else if (r_clusters >= FAT32_MIN) begin
            w_kind = FAT_32;
        end else if (r_clusters >= FAT16_MIN) begin
            w_kind = FAT_16;
        end else begin
            w_kind = FAT_12;
        end
        if (w_sig) begin
            w_tdata = {7'd0, r_ext, w_serial, r_spc, r_bps, w_total, w_root_out,
                       r_database, r_rsv, w_entries, w_clus};
            w_tuser = {w_kind, w_ok};
        end else begin
            w_tdata = '0;
            w_tuser = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_tdata;
            r_out_user <= w_tuser;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_m_ready;
    assign o_m_valid         = r_out_valid;
    assign o_m_data          = r_out_data;
    assign o_m_user          = r_out_user;

endmodule

>>> hw/rtl/fbs_ctrl.sv
// ----------------------------------------------------------------------------
// fbs_ctrl
// sequencer: byte collection, root directory division, overhead, cluster
// division and hand-off of the result
// ----------------------------------------------------------------------------
module fbs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  logic             i_s_last,
    output logic             o_s_ready,
    input  fbs_pkg::t_status i_status,
    output fbs_pkg::t_cmd    o_cmd
);
    import fbs_pkg::*;

    typedef enum logic [5:0] {
        S_COLLECT   = 6'b000001,
        S_BASE      = 6'b000010,
        S_ROOT_WAIT = 6'b000100,
        S_OVH       = 6'b001000,
        S_CLUS      = 6'b010000,
        S_CLUS_WAIT = 6'b100000
    } t_state;

    typedef enum logic [0:0] {
        E_NONE = 1'b0,
        E_EMIT = 1'b1
    } t_emit;

    t_state r_state, n_state;
    t_emit  r_emit, n_emit;
    logic   w_accept;

    assign w_accept = i_s_valid && o_s_ready;

    always_comb begin
        n_state   = r_state;
        n_emit    = E_NONE;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_COLLECT: begin
                o_s_ready = (r_emit == E_NONE);
                if (r_emit == E_EMIT) begin
                    if (i_status.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.clear    = 1'b1;
                    end else begin
                        n_emit = E_EMIT;
                    end
                end else if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_s_last) n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.base_load  = 1'b1;
                o_cmd.root_start = 1'b1;
                n_state          = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.root_load = 1'b1;
                    n_state         = S_OVH;
                end
            end
            S_OVH: begin
                o_cmd.ovh_load = 1'b1;
                n_state        = S_CLUS;
            end
            S_CLUS: begin
                o_cmd.clus_start = 1'b1;
                n_state          = S_CLUS_WAIT;
            end
            S_CLUS_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.clus_load = 1'b1;
                    n_state         = S_COLLECT;
                    n_emit          = E_EMIT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_emit  <= E_NONE;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

endmodule

>>> hw/rtl/fat_boot_sector_parser.sv
// ----------------------------------------------------------------------------
// fat_boot_sector_parser
// top level: parses the parameter block of a FAT boot sector from a byte
// stream and reports the volume geometry
// ----------------------------------------------------------------------------
// Boot-sector bytes are taken one per cycle from offset 0, and the byte with
// tlast set ends the sector. The block then holds s_axis_tready low while a
// shared 32-step radix-2 divider runs twice, once for the root directory
// sector count and once for the cluster count, plus the steps for the FAT
// base, overhead and result load. The result sits in an output register; if
// it has not yet been taken, the block waits there before accepting the next
// sector. A bad jump signature gives an all-zero result, and ok is low
// whenever the geometry is not usable.
module fat_boot_sector_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // data_byte
    input  logic                          s_axis_tlast,   // last_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // cluster_count, fat_entry_count, fat_base_sector, data_base_sector,
    // root_dir_sector_count, total_sector_count, sector_bytes, cluster_sectors,
    // volume_serial, has_extended, zero fill
    output logic [fbs_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [fbs_pkg::TUSER_W-1:0]   m_axis_tuser    // ok, fat_kind
);
    import fbs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    fbs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    fbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_data_byte (s_axis_tdata),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser)
    );

endmodule

>>> hw/rtl/fbs_checker.sv
// ----------------------------------------------------------------------------
// fbs_checker
// port-level checks on the fat boot sector parser, bound to the top level
// ----------------------------------------------------------------------------
module fbs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [215:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    // held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // end of sector stalls input for the divisions
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after last byte");

    // failed geometry reports no clusters
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[63:0] == 64'd0 && m_axis_tuser[2:1] == 2'd0)
        else $error("cluster fields set without ok");

    // entry count tracks cluster count
    a_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[63:32] == m_axis_tdata[31:0] + 32'd2)
        else $error("fat entry count mismatch");

endmodule

bind fat_boot_sector_parser fbs_checker u_checker (.*);
